// ----- src/avcc_pkg.sv -----
// Shared types and constants for the length-prefixed to start-code NAL converter.
// No dependencies; used by avcc_pstore and avcc_to_annexb_nal_converter.
package avcc_pkg;

   // Input word: one frame byte or one parameter-set byte
   typedef struct packed {
      logic        req_type;
      logic [7:0]  data_byte;
      logic        first_flag;
      logic [23:0] frame_size;
   } req_word_type;

   // Result word: one stream byte or one error indication
   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_last;
      logic [1:0] status;
   } rsp_word_type;

   // Write request into the parameter-set store
   typedef struct packed {
      logic       wr_en;
      logic       restart;
      logic [7:0] data;
   } pst_wr_type;

   localparam logic       REQ_FRAME      = 1'b0;
   localparam logic       REQ_PARAM      = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_TRUNC   = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

   localparam int         LEN_BITS       = 32;
   localparam logic [7:0] NAL_TYPE_MASK  = 8'h1F;
   localparam logic [7:0] NAL_TYPE_IDR   = 8'd5;
   localparam int         PREFIX_BYTES   = 4;
   localparam int         START_CODE_LEN = 3;
   localparam logic [7:0] START_CODE_END = 8'h01;

endpackage

// ----- src/avcc_pstore.sv -----
// Parameter-set byte store: memory, fill length and registered read port.
// Depends on avcc_pkg (pst_wr_type).
module avcc_pstore #(
   parameter int PARAM_DEPTH = 60,
   parameter int PLEN_W      = $clog2(PARAM_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  avcc_pkg::pst_wr_type   wr,
   input  logic [PLEN_W-1:0]      rd_addr,
   output logic [7:0]             rd_data,
   output logic [PLEN_W-1:0]      param_length
);

   localparam int AW = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;

   logic [7:0]        mem [PARAM_DEPTH];
   logic [PLEN_W-1:0] plen_ff, plen_in;
   logic [PLEN_W-1:0] wr_idx;
   logic              wr_ok;
   logic [7:0]        rd_data_ff;

   // restart loads from entry 0; a full store ignores further bytes
   assign wr_idx = wr.restart ? '0 : plen_ff;
   assign wr_ok  = wr.wr_en && (wr_idx < PLEN_W'(PARAM_DEPTH));

   always_comb begin
      plen_in = plen_ff;
      if (wr_ok) begin
         plen_in = wr_idx + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0;
      end else begin
         plen_ff <= plen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_idx[AW-1:0]] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_addr < PLEN_W'(PARAM_DEPTH)) begin
         rd_data_ff <= mem[rd_addr[AW-1:0]];
      end
   end

   assign rd_data      = rd_data_ff;
   assign param_length = plen_ff;

endmodule

// ----- src/avcc_to_annexb_nal_converter.sv -----
// Top level: length-prefixed H.264 frame bytes in, Annex B stream bytes out.
// Depends on avcc_pkg and avcc_pstore.
//
//  channel  ports                         direction  moves
//  -------  ----------------------------  ---------  ------------------------------
//  request  req_valid req_stall req_data  in         frame byte or param-set byte
//  result   rsp_valid rsp_stall rsp_data  out        stream byte or error word
//
// Flow: a word with no result or one result is taken without holding the input.
// The first payload byte of a NAL holds the input from the take while the emit
// sequencer sends three start-code words and then the byte, and on an IDR unit
// the param_length parameter-set bytes before them, one result word per cycle
// unless the result is stalled, reading the parameter store one entry a cycle.
// Reset: synchronous, active high; clears parser phase, counters and output valid.
// The parameter store has no clear pass; only written entries are ever read.
// Stalls: req_stall is high while the emit sequencer runs, or while the result
// register holds a word that is stalled.
module avcc_to_annexb_nal_converter #(
   parameter int PARAM_DEPTH     = 60,
   parameter int FRAME_SIZE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  avcc_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output avcc_pkg::rsp_word_type rsp_data
);

   localparam int FSB    = FRAME_SIZE_BITS;
   localparam int LB     = avcc_pkg::LEN_BITS;
   localparam int PLEN_W = $clog2(PARAM_DEPTH + 1);

   // parser phase codes
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_LENGTH  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_DROP    = 2'd3;

   // emit sequencer codes
   localparam logic [1:0] SQ_IDLE    = 2'd0;
   localparam logic [1:0] SQ_PARAM   = 2'd1;
   localparam logic [1:0] SQ_START   = 2'd2;
   localparam logic [1:0] SQ_BYTE    = 2'd3;

   localparam logic [1:0] PREFIX_LAST = 2'(avcc_pkg::PREFIX_BYTES - 1);
   localparam logic [1:0] SC_LAST     = 2'(avcc_pkg::START_CODE_LEN - 1);

   // parser state
   logic [1:0]     phase_ff,  phase_in;
   logic [1:0]     prefix_ff, prefix_in;
   logic [LB-1:0]  accum_ff,  accum_in;
   logic [FSB-1:0] nal_ff,    nal_in;
   logic [FSB-1:0] frame_ff,  frame_in;

   // emit sequencer
   logic [1:0]        seq_ff,  seq_in;
   logic [PLEN_W-1:0] pidx_ff, pidx_in;
   logic [PLEN_W-1:0] pidx_next;
   logic [1:0]        sc_ff,   sc_in;
   logic [7:0]        hold_byte_ff, hold_byte_in;
   logic              hold_end_ff,  hold_end_in;

   // result register
   logic                   rsp_valid_ff;
   avcc_pkg::rsp_word_type rsp_data_ff;
   logic                   out_free;
   logic                   out_load;
   avcc_pkg::rsp_word_type out_word;

   // working values for the word being taken
   logic           req_accept;
   logic [FSB-1:0] frame_size_cut;
   logic [1:0]     cur_phase;
   logic [1:0]     cur_prefix;
   logic [LB-1:0]  cur_accum;
   logic [FSB-1:0] cur_nal;
   logic [FSB-1:0] cur_fleft;
   logic [FSB-1:0] frame_dec;
   logic [FSB-1:0] nal_dec;
   logic [LB-1:0]  accum_shift;
   logic           frame_over;
   logic           is_idr;

   // parameter store link
   avcc_pkg::pst_wr_type pst_wr;
   logic [7:0]           pst_rd_data;
   logic [PLEN_W-1:0]    param_length;

   avcc_pstore #(
      .PARAM_DEPTH (PARAM_DEPTH),
      .PLEN_W      (PLEN_W)
   ) u_pstore (
      .clock        (clock),
      .reset        (reset),
      .wr           (pst_wr),
      .rd_addr      (pidx_in),
      .rd_data      (pst_rd_data),
      .param_length (param_length)
   );

   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign req_stall      = (seq_ff != SQ_IDLE) || !out_free;
   assign req_accept     = req_valid && !req_stall;
   assign frame_size_cut = FSB'(req_data.frame_size);
   assign is_idr         = (req_data.data_byte & avcc_pkg::NAL_TYPE_MASK)
                           == avcc_pkg::NAL_TYPE_IDR;
   assign pidx_next      = pidx_ff + 1'b1;

   always_comb begin
      phase_in     = phase_ff;
      prefix_in    = prefix_ff;
      accum_in     = accum_ff;
      nal_in       = nal_ff;
      frame_in     = frame_ff;
      seq_in       = seq_ff;
      pidx_in      = pidx_ff;
      sc_in        = sc_ff;
      hold_byte_in = hold_byte_ff;
      hold_end_in  = hold_end_ff;
      out_load     = 1'b0;
      out_word     = '0;
      pst_wr       = '0;
      cur_phase    = phase_ff;
      cur_prefix   = prefix_ff;
      cur_accum    = accum_ff;
      cur_nal      = nal_ff;
      cur_fleft    = frame_ff;
      frame_dec    = '0;
      nal_dec      = '0;
      accum_shift  = '0;
      frame_over   = 1'b0;

      unique case (seq_ff)
         SQ_IDLE: begin
            // read pointer parked at entry 0 so the first param byte is ready
            pidx_in = '0;
            if (req_accept) begin
               if (req_data.req_type == avcc_pkg::REQ_PARAM) begin
                  pst_wr.wr_en   = 1'b1;
                  pst_wr.restart = req_data.first_flag;
                  pst_wr.data    = req_data.data_byte;
               end else begin
                  // a new frame drops whatever was in flight
                  if (req_data.first_flag) begin
                     cur_fleft  = frame_size_cut;
                     cur_phase  = (frame_size_cut != '0) ? PH_LENGTH : PH_IDLE;
                     cur_prefix = '0;
                     cur_accum  = '0;
                     cur_nal    = '0;
                  end
                  phase_in  = cur_phase;
                  prefix_in = cur_prefix;
                  accum_in  = cur_accum;
                  nal_in    = cur_nal;
                  frame_in  = cur_fleft;
                  frame_dec = cur_fleft - 1'b1;
                  nal_dec   = cur_nal - 1'b1;

                  unique case (cur_phase)
                     PH_IDLE: begin
                     end
                     PH_DROP: begin
                        if (cur_fleft <= FSB'(1)) begin
                           frame_in = '0;
                           phase_in = PH_IDLE;
                        end else begin
                           frame_in = frame_dec;
                        end
                     end
                     PH_LENGTH: begin
                        if (cur_prefix == '0 &&
                            cur_fleft < FSB'(avcc_pkg::PREFIX_BYTES)) begin
                           // not enough bytes left for a length
                           frame_in  = (cur_fleft != '0) ? frame_dec : '0;
                           phase_in  = (cur_fleft > FSB'(1)) ? PH_DROP : PH_IDLE;
                           prefix_in = '0;
                           accum_in  = '0;
                           nal_in    = '0;
                           out_load            = 1'b1;
                           out_word.run_last   = 1'b1;
                           out_word.frame_last = 1'b1;
                           out_word.status     = avcc_pkg::STATUS_TRUNC;
                        end else begin
                           accum_shift = {cur_accum[LB-9:0], req_data.data_byte};
                           frame_in    = frame_dec;
                           if (cur_prefix != PREFIX_LAST) begin
                              prefix_in = cur_prefix + 1'b1;
                              accum_in  = accum_shift;
                           end else begin
                              prefix_in = '0;
                              if (accum_shift == '0 || accum_shift > LB'(frame_dec)) begin
                                 phase_in = (frame_dec != '0) ? PH_DROP : PH_IDLE;
                                 accum_in = '0;
                                 nal_in   = '0;
                                 out_load            = 1'b1;
                                 out_word.run_last   = 1'b1;
                                 out_word.frame_last = 1'b1;
                                 out_word.status     = avcc_pkg::STATUS_BAD_LEN;
                              end else begin
                                 accum_in = accum_shift;
                                 nal_in   = FSB'(accum_shift);
                                 phase_in = PH_PAYLOAD;
                              end
                           end
                        end
                     end
                     PH_PAYLOAD: begin
                        nal_in   = nal_dec;
                        frame_in = frame_dec;
                        if (nal_dec == '0) begin
                           accum_in  = '0;
                           prefix_in = '0;
                           if (frame_dec == '0) begin
                              phase_in   = PH_IDLE;
                              frame_over = 1'b1;
                           end else begin
                              phase_in = PH_LENGTH;
                           end
                        end
                        // nal count still equal to the length: NAL header byte
                        if (LB'(cur_nal) == cur_accum) begin
                           hold_byte_in = req_data.data_byte;
                           hold_end_in  = frame_over;
                           sc_in        = '0;
                           seq_in = (is_idr && param_length != '0) ? SQ_PARAM : SQ_START;
                        end else begin
                           out_load            = 1'b1;
                           out_word.byte_valid = 1'b1;
                           out_word.out_byte   = req_data.data_byte;
                           out_word.run_last   = 1'b1;
                           out_word.frame_last = frame_over;
                           out_word.status     = avcc_pkg::STATUS_OK;
                        end
                     end
                  endcase
               end
            end
         end
         SQ_PARAM: begin
            if (out_free) begin
               out_load            = 1'b1;
               out_word.byte_valid = 1'b1;
               out_word.out_byte   = pst_rd_data;
               pidx_in             = pidx_next;
               if (pidx_next == param_length) begin
                  seq_in = SQ_START;
               end
            end
         end
         SQ_START: begin
            if (out_free) begin
               out_load            = 1'b1;
               out_word.byte_valid = 1'b1;
               out_word.out_byte   = (sc_ff == SC_LAST) ? avcc_pkg::START_CODE_END : 8'h00;
               sc_in               = sc_ff + 1'b1;
               if (sc_ff == SC_LAST) begin
                  seq_in = SQ_BYTE;
               end
            end
         end
         SQ_BYTE: begin
            if (out_free) begin
               out_load            = 1'b1;
               out_word.byte_valid = 1'b1;
               out_word.out_byte   = hold_byte_ff;
               out_word.run_last   = 1'b1;
               out_word.frame_last = hold_end_ff;
               out_word.status     = avcc_pkg::STATUS_OK;
               seq_in              = SQ_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         prefix_ff    <= '0;
         accum_ff     <= '0;
         nal_ff       <= '0;
         frame_ff     <= '0;
         seq_ff       <= SQ_IDLE;
         pidx_ff      <= '0;
         sc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         prefix_ff <= prefix_in;
         accum_ff  <= accum_in;
         nal_ff    <= nal_in;
         frame_ff  <= frame_in;
         seq_ff    <= seq_in;
         pidx_ff   <= pidx_in;
         sc_ff     <= sc_in;
         if (out_free) begin
            rsp_valid_ff <= out_load;
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_byte_ff <= hold_byte_in;
      hold_end_ff  <= hold_end_in;
      if (out_load) begin
         rsp_data_ff <= out_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
